### design/mmhb_pkg.sv
// Shared constants and codes for the multi min-heap bank.
// Used by the top level and the port checker; no dependencies.
`default_nettype none
package mmhb_pkg;
   localparam int NUM_HEAPS     = 16;
   localparam int HEAP_CAPACITY = 256;
   localparam int KEY_BITS      = 32;
   localparam int ID_W          = $clog2(NUM_HEAPS);
   localparam int IDX_W         = $clog2(HEAP_CAPACITY);
   localparam int SIZE_W        = IDX_W + 1;
   localparam int USE_W         = ID_W + 1;
   localparam int ADDR_W        = ID_W + IDX_W;
   localparam int DEPTH         = NUM_HEAPS * HEAP_CAPACITY;

   typedef enum logic [2:0] {
      ACT_CREATE   = 3'd0,
      ACT_INSERT   = 3'd1,
      ACT_EXTRACT  = 3'd2,
      ACT_MERGE    = 3'd3,
      ACT_DECREASE = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_NO_HEAP = 2'd2,
      ST_FULL    = 2'd3
   } status_type;
endpackage
`default_nettype wire

### design/mmhb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module mmhb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

### design/multi_min_heap_bank_unit.sv
// Top level of the multi min-heap bank: sequencer, heap sizes and key RAM.
// Depends on mmhb_pkg and mmhb_ram.
//
//  channel | ports                               | handshake
//  request | req_action, req_heap_id, ...        | start, busy
//  response| rsp_status, rsp_min_value, ...       | rsp_valid strobe
//
// Create, insert, failing items and unused codes answer the cycle after start.
// Extract_min and decrease_key on a heap of n > 0 keys scan it through the RAM
// read port, then answer; on an empty heap they answer the cycle after start.
// Merge copies n1 + n2 words through the RAM into a new heap. Busy stays high
// until the cycle of the response.
// Reset clears sizes and the heap count; the key RAM needs no clearing.
// The response strobe lasts one cycle and cannot be held off.
`default_nettype none
module multi_min_heap_bank_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [2:0]                 req_action,
   input  wire logic [mmhb_pkg::ID_W-1:0]  req_heap_id,
   input  wire logic [mmhb_pkg::ID_W-1:0]  req_second_heap_id,
   input  wire logic signed [31:0]         req_key_value,
   input  wire logic signed [31:0]         req_new_key_value,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic signed [31:0]              rsp_min_value,
   output logic [mmhb_pkg::ID_W-1:0]       rsp_created_heap_id
);
   import mmhb_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COPY, S_FIX} state_type;

   state_type                  state_ff;
   logic [2:0]                 op_ff;
   logic [ID_W-1:0]            id_ff, id2_ff, dst_ff;
   logic signed [KEY_BITS-1:0] key_ff, nkey_ff;
   logic [SIZE_W-1:0]          n_ff, total_ff, cnt_ff;
   logic                       rd_valid_ff;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic signed [KEY_BITS-1:0] min_ff, last_ff;
   logic [IDX_W-1:0]           pos_ff;
   logic                       found_ff;
   logic [SIZE_W-1:0]          sizes_ff [NUM_HEAPS];
   logic [USE_W-1:0]           in_use_ff;
   logic                       rsp_valid_ff;
   status_type                 rsp_status_ff;
   logic signed [31:0]         rsp_min_ff;
   logic [ID_W-1:0]            rsp_cid_ff;

   logic                       wr_en, rd_en;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic [KEY_BITS-1:0]        wr_data, rd_data;
   logic                       accept, exists, exists2, bank_full;
   logic [SIZE_W-1:0]          n_req, n2_req, k_off;
   logic [SIZE_W:0]            sum_req;

   assign accept    = start && (state_ff == S_IDLE);
   assign exists    = {1'b0, req_heap_id} < in_use_ff;
   assign exists2   = {1'b0, req_second_heap_id} < in_use_ff;
   assign bank_full = in_use_ff == USE_W'(NUM_HEAPS);
   assign n_req     = sizes_ff[req_heap_id];
   assign n2_req    = sizes_ff[req_second_heap_id];
   assign sum_req   = {1'b0, n_req} + {1'b0, n2_req};
   assign k_off     = cnt_ff - n_ff;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = {id_ff, cnt_ff[IDX_W-1:0]};
      if (state_ff == S_SCAN && cnt_ff < n_ff) begin
         rd_en = 1'b1;
      end else if (state_ff == S_COPY && cnt_ff < total_ff) begin
         rd_en = 1'b1;
         if (cnt_ff >= n_ff) begin
            rd_addr = {id2_ff, k_off[IDX_W-1:0]};
         end
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {req_heap_id, n_req[IDX_W-1:0]};
      wr_data = req_key_value;
      unique case (state_ff)
         S_IDLE: begin
            wr_en = accept && req_action == ACT_INSERT && exists &&
                    n_req != SIZE_W'(HEAP_CAPACITY);
         end
         S_COPY: begin
            wr_en   = rd_valid_ff;
            wr_addr = {dst_ff, rd_idx_ff};
            wr_data = rd_data;
         end
         S_FIX: begin
            wr_addr = {id_ff, pos_ff};
            if (op_ff == ACT_EXTRACT) begin
               wr_en   = 1'b1;
               wr_data = last_ff;
            end else begin
               wr_en   = found_ff;
               wr_data = nkey_ff;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   mmhb_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      rd_valid_ff  <= rd_en;
      rd_idx_ff    <= cnt_ff[IDX_W-1:0];
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_valid_ff <= 1'b0;
         in_use_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_HEAPS; i++) begin
            sizes_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff         <= req_action;
                  id_ff         <= req_heap_id;
                  id2_ff        <= req_second_heap_id;
                  key_ff        <= req_key_value;
                  nkey_ff       <= req_new_key_value;
                  n_ff          <= n_req;
                  total_ff      <= sum_req[SIZE_W-1:0];
                  dst_ff        <= in_use_ff[ID_W-1:0];
                  cnt_ff        <= '0;
                  found_ff      <= 1'b0;
                  rsp_status_ff <= ST_OK;
                  rsp_min_ff    <= '0;
                  rsp_cid_ff    <= '0;
                  rsp_valid_ff  <= 1'b1;
                  unique case (req_action)
                     ACT_CREATE: begin
                        if (bank_full) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           sizes_ff[in_use_ff[ID_W-1:0]] <= '0;
                           rsp_cid_ff <= in_use_ff[ID_W-1:0];
                           in_use_ff  <= in_use_ff + 1'b1;
                        end
                     end
                     ACT_INSERT: begin
                        if (!exists) begin
                           rsp_status_ff <= ST_NO_HEAP;
                        end else if (n_req == SIZE_W'(HEAP_CAPACITY)) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           sizes_ff[req_heap_id] <= n_req + 1'b1;
                        end
                     end
                     ACT_EXTRACT: begin
                        if (!exists) begin
                           rsp_status_ff <= ST_NO_HEAP;
                        end else if (n_req == '0) begin
                           rsp_status_ff <= ST_EMPTY;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= S_SCAN;
                        end
                     end
                     ACT_MERGE: begin
                        if (!exists || !exists2) begin
                           rsp_status_ff <= ST_NO_HEAP;
                        end else if (bank_full ||
                                     sum_req > (SIZE_W+1)'(HEAP_CAPACITY)) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= S_COPY;
                        end
                     end
                     ACT_DECREASE: begin
                        if (!exists) begin
                           rsp_status_ff <= ST_NO_HEAP;
                        end else if (n_req != '0) begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= S_SCAN;
                        end
                     end
                     default: begin
                        rsp_status_ff <= ST_OK;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (rd_en) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (rd_valid_ff) begin
                  last_ff <= rd_data;
                  if (op_ff == ACT_EXTRACT) begin
                     if (rd_idx_ff == '0 || $signed(rd_data) < min_ff) begin
                        min_ff <= rd_data;
                        pos_ff <= rd_idx_ff;
                     end
                  end else if (!found_ff && rd_data == key_ff) begin
                     found_ff <= 1'b1;
                     pos_ff   <= rd_idx_ff;
                  end
               end else if (cnt_ff == n_ff) begin
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               if (op_ff == ACT_EXTRACT) begin
                  sizes_ff[id_ff] <= n_ff - 1'b1;
                  rsp_min_ff      <= min_ff;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_COPY: begin
               if (rd_en) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end else if (!rd_valid_ff) begin
                  sizes_ff[dst_ff] <= total_ff;
                  in_use_ff        <= in_use_ff + 1'b1;
                  rsp_cid_ff       <= dst_ff;
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                = state_ff != S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_min_value       = rsp_min_ff;
   assign rsp_created_heap_id = rsp_cid_ff;
endmodule
`default_nettype wire

### design/mmhb_checker.sv
// Port-level checks for the multi min-heap bank, bound to the top level.
// Depends on mmhb_pkg and multi_min_heap_bank_unit.
`default_nettype none
module mmhb_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire logic [2:0]                req_action,
   input wire logic                      rsp_valid,
   input wire logic [1:0]                rsp_status,
   input wire logic [31:0]               rsp_min_value,
   input wire logic [mmhb_pkg::ID_W-1:0] rsp_created_heap_id
);
   import mmhb_pkg::*;

   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");

   a_short_ops: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_CREATE || req_action == ACT_INSERT))
      |=> rsp_valid) else $error("short item gave no response");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
      (rsp_min_value == '0 && rsp_created_heap_id == '0))
      else $error("failed response carries data");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("long item ended without response");
endmodule

bind multi_min_heap_bank_unit mmhb_checker u_mmhb_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_action         (req_action),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_min_value      (rsp_min_value),
   .rsp_created_heap_id(rsp_created_heap_id)
);
`default_nettype wire
